FILE: design/ivmap_pkg.sv
package ivmap_pkg;

  localparam int WINDOW_MAX = 64;

  localparam int WIN_AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int CFG_LEN_W  = 7;
  localparam int LEN_CMP_W  = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int LEN_RESET  = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;

  localparam int SMP_W      = 16;
  localparam int VOLT_W     = 17;
  localparam int OFF_W      = 17;
  localparam int GAIN_W     = 32;
  localparam int ADJ_W      = 18;
  localparam int SCL_W      = 32;
  localparam int PROD_W     = 64;
  localparam int WORD_W     = SMP_W + VOLT_W;

  localparam int DIV_W      = SMP_W + WIN_AW;
  localparam int CSUM_W     = DIV_W;
  localparam int VSUM_W     = DIV_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_FIELD_W = SMP_W + VOLT_W + 2 * SCL_W + PROD_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CURRENT_OFFSET = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CURRENT_GAIN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_VOLTAGE_OFFSET = 3'd3;
  localparam logic [CFG_AW-1:0] REG_VOLTAGE_GAIN   = 3'd4;

  typedef enum logic [1:0] {
    MUL_CUR  = 2'd0,
    MUL_VOLT = 2'd1,
    MUL_PWR  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     update;
    logic     div_start;
    logic     div_volt;
    logic     cap_cavg;
    logic     cap_vavg;
    logic     adj_c;
    logic     adj_v;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sat_c;
    logic     sat_v;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: design/ivmap_ram.sv
module ivmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ivmap_div.sv
module ivmap_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ivmap_pkg::DIV_W-1:0]   dividend,
  input  logic [ivmap_pkg::LEN_W-1:0]   divisor,
  output logic                          done,
  output logic [ivmap_pkg::DIV_W-1:0]   quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [ivmap_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ivmap_pkg::LEN_W-1:0]       rem_r, rem_nxt;
  logic [ivmap_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [ivmap_pkg::LEN_W-1:0]       dsr_r, dsr_nxt;
  logic [ivmap_pkg::LEN_W:0]         shifted;
  logic [ivmap_pkg::LEN_W+1:0]       trial;
  logic                              fits;

  assign shifted = {rem_r, quo_r[ivmap_pkg::DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = !trial[ivmap_pkg::LEN_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    done_nxt = busy_r && (cnt_r == '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ivmap_pkg::DIV_CNT_W'(ivmap_pkg::DIV_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[ivmap_pkg::LEN_W-1:0] : shifted[ivmap_pkg::LEN_W-1:0];
      quo_nxt = {quo_r[ivmap_pkg::DIV_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: design/ivmap_datapath.sv
module ivmap_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ivmap_pkg::cmd_t                     cmd,
  output ivmap_pkg::sts_t                     sts,
  input  logic [ivmap_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                cfg_wr,
  input  logic [ivmap_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [ivmap_pkg::CFG_DW-1:0]        cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ivmap_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // configuration
  logic        [ivmap_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic signed [ivmap_pkg::OFF_W-1:0]   coff_r, voff_r;
  logic signed [ivmap_pkg::GAIN_W-1:0]  cgain_r, vgain_r;
  logic        [ivmap_pkg::LEN_CMP_W-1:0] len_req;
  logic                                 restart;

  // window state
  logic        [ivmap_pkg::WIN_AW-1:0]  pos_r, pos_nxt;
  logic        [ivmap_pkg::LEN_W-1:0]   fill_r, fill_nxt;
  logic        [ivmap_pkg::CSUM_W-1:0]  csum_r, csum_nxt;
  logic signed [ivmap_pkg::VSUM_W-1:0]  vsum_r, vsum_nxt;
  logic                                 full;
  logic        [ivmap_pkg::WIN_AW:0]    pos_inc;

  // sample capture
  logic        [ivmap_pkg::SMP_W-1:0]   smp_c_r;
  logic signed [ivmap_pkg::VOLT_W-1:0]  smp_v_r;
  logic        [ivmap_pkg::WORD_W-1:0]  ram_rdata;
  logic        [ivmap_pkg::SMP_W-1:0]   old_c;
  logic signed [ivmap_pkg::VOLT_W-1:0]  old_v;

  // division and calibration
  logic                                 div_done;
  logic        [ivmap_pkg::DIV_W-1:0]   div_q;
  logic        [ivmap_pkg::DIV_W-1:0]   div_a;
  logic signed [ivmap_pkg::VSUM_W-1:0]  vmag;
  logic                                 vneg;
  logic        [ivmap_pkg::SMP_W-1:0]   cavg_r;
  logic signed [ivmap_pkg::VOLT_W-1:0]  vavg_r;
  logic signed [ivmap_pkg::VOLT_W-1:0]  vq;
  logic signed [ivmap_pkg::ADJ_W-1:0]   cadj_r, vadj_r;
  logic signed [ivmap_pkg::SCL_W-1:0]   mul_a, mul_b;
  logic signed [ivmap_pkg::PROD_W-1:0]  mul_p;
  logic signed [ivmap_pkg::PROD_W-1:0]  prod_r;
  logic signed [ivmap_pkg::SCL_W-1:0]   prod_sat;
  logic signed [ivmap_pkg::SCL_W-1:0]   cs_r, vs_r;

  // output stage
  logic                                 out_valid_r;
  logic [ivmap_pkg::OUT_FIELD_W-1:0]    out_r;

  assign restart = cfg_wr && (cfg_addr == ivmap_pkg::REG_WINDOW_LENGTH);
  assign len_req = ivmap_pkg::LEN_CMP_W'(cfg_data[ivmap_pkg::CFG_LEN_W-1:0]);

  always_comb begin
    if (len_req == '0) begin
      len_nxt = ivmap_pkg::LEN_W'(1);
    end else if (len_req > ivmap_pkg::LEN_CMP_W'(ivmap_pkg::WINDOW_MAX)) begin
      len_nxt = ivmap_pkg::LEN_W'(ivmap_pkg::WINDOW_MAX);
    end else begin
      len_nxt = len_req[ivmap_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= ivmap_pkg::LEN_W'(ivmap_pkg::LEN_RESET);
      coff_r  <= '0;
      cgain_r <= ivmap_pkg::GAIN_W'(65536);
      voff_r  <= '0;
      vgain_r <= ivmap_pkg::GAIN_W'(65536);
    end else if (cfg_wr) begin
      case (cfg_addr)
        ivmap_pkg::REG_WINDOW_LENGTH:  len_r   <= len_nxt;
        ivmap_pkg::REG_CURRENT_OFFSET: coff_r  <= cfg_data[ivmap_pkg::OFF_W-1:0];
        ivmap_pkg::REG_CURRENT_GAIN:   cgain_r <= cfg_data[ivmap_pkg::GAIN_W-1:0];
        ivmap_pkg::REG_VOLTAGE_OFFSET: voff_r  <= cfg_data[ivmap_pkg::OFF_W-1:0];
        ivmap_pkg::REG_VOLTAGE_GAIN:   vgain_r <= cfg_data[ivmap_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_c_r <= in_tdata[15:0];
      smp_v_r <= $signed({1'b0, in_tdata[31:16]}) - $signed({1'b0, in_tdata[47:32]});
    end
  end

  ivmap_ram #(
    .WIDTH (ivmap_pkg::WORD_W),
    .DEPTH (ivmap_pkg::WINDOW_MAX)
  ) u_win (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos_r),
    .wdata ({smp_v_r, smp_c_r}),
    .re    (cmd.accept),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign old_c = ram_rdata[ivmap_pkg::SMP_W-1:0];
  assign old_v = ram_rdata[ivmap_pkg::WORD_W-1:ivmap_pkg::SMP_W];

  assign full    = (fill_r >= len_r);
  assign pos_inc = {1'b0, pos_r} + 1'b1;

  always_comb begin
    csum_nxt = csum_r + ivmap_pkg::CSUM_W'(smp_c_r);
    vsum_nxt = vsum_r + ivmap_pkg::VSUM_W'(smp_v_r);
    if (full) begin
      csum_nxt = csum_nxt - ivmap_pkg::CSUM_W'(old_c);
      vsum_nxt = vsum_nxt - ivmap_pkg::VSUM_W'(old_v);
    end
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    if (16'(pos_inc) >= 16'(len_r)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[ivmap_pkg::WIN_AW-1:0];
    end
  end

  assign sts.emit = (fill_nxt >= len_r);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_r  <= '0;
      fill_r <= '0;
      csum_r <= '0;
      vsum_r <= '0;
    end else if (cmd.update) begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      csum_r <= csum_nxt;
      vsum_r <= vsum_nxt;
    end
  end

  assign vneg  = vsum_r[ivmap_pkg::VSUM_W-1];
  assign vmag  = vneg ? -vsum_r : vsum_r;
  assign div_a = cmd.div_volt ? vmag[ivmap_pkg::DIV_W-1:0] : csum_r;

  ivmap_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.div_done = div_done;
  assign vq = $signed(div_q[ivmap_pkg::VOLT_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.cap_cavg) begin
      cavg_r <= div_q[ivmap_pkg::SMP_W-1:0];
    end
    if (cmd.cap_vavg) begin
      vavg_r <= vneg ? -vq : vq;
    end
    if (cmd.adj_c) begin
      cadj_r <= $signed({2'b00, cavg_r}) + ivmap_pkg::ADJ_W'(coff_r);
    end
    if (cmd.adj_v) begin
      vadj_r <= ivmap_pkg::ADJ_W'(vavg_r) + ivmap_pkg::ADJ_W'(voff_r);
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      ivmap_pkg::MUL_CUR: begin
        mul_a = ivmap_pkg::SCL_W'(cadj_r);
        mul_b = cgain_r;
      end
      ivmap_pkg::MUL_VOLT: begin
        mul_a = ivmap_pkg::SCL_W'(vadj_r);
        mul_b = vgain_r;
      end
      ivmap_pkg::MUL_PWR: begin
        mul_a = cs_r;
        mul_b = vs_r;
      end
      default: begin
        mul_a = cs_r;
        mul_b = vs_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (prod_r > 64'sd2147483647) begin
      prod_sat = 32'sh7fffffff;
    end else if (prod_r < -64'sd2147483648) begin
      prod_sat = 32'sh80000000;
    end else begin
      prod_sat = prod_r[ivmap_pkg::SCL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.sat_c) begin
      cs_r <= prod_sat;
    end
    if (cmd.sat_v) begin
      vs_r <= prod_sat;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_r <= {prod_r, vs_r, cs_r, vavg_r, cavg_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ivmap_pkg::OUT_TDATA_W - ivmap_pkg::OUT_FIELD_W)'(0), out_r};

endmodule

FILE: design/ivmap_ctrl.sv
module ivmap_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ivmap_pkg::sts_t  sts,
  output ivmap_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_UPDATE    = 11'b000_0000_0010,
    S_DIVC_GO   = 11'b000_0000_0100,
    S_DIVC_WAIT = 11'b000_0000_1000,
    S_DIVV_GO   = 11'b000_0001_0000,
    S_DIVV_WAIT = 11'b000_0010_0000,
    S_MUL_C     = 11'b000_0100_0000,
    S_MUL_V     = 11'b000_1000_0000,
    S_SAT_V     = 11'b001_0000_0000,
    S_MUL_P     = 11'b010_0000_0000,
    S_LOAD      = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = ivmap_pkg::MUL_CUR;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.emit ? S_DIVC_GO : S_IDLE;
      end
      S_DIVC_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVC_WAIT;
      end
      S_DIVC_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_cavg = 1'b1;
          state_nxt    = S_DIVV_GO;
        end
      end
      S_DIVV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_volt  = 1'b1;
        cmd.adj_c     = 1'b1;
        state_nxt     = S_DIVV_WAIT;
      end
      S_DIVV_WAIT: begin
        cmd.div_volt = 1'b1;
        if (sts.div_done) begin
          cmd.cap_vavg = 1'b1;
          state_nxt    = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd.adj_v   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ivmap_pkg::MUL_CUR;
        state_nxt   = S_MUL_V;
      end
      S_MUL_V: begin
        cmd.sat_c   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ivmap_pkg::MUL_VOLT;
        state_nxt   = S_SAT_V;
      end
      S_SAT_V: begin
        cmd.sat_v = 1'b1;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ivmap_pkg::MUL_PWR;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/iv_moving_average_power.sv
// Boxcar moving average of current and differential voltage with linear
// calibration and power. One sample set is taken per input transfer; no
// result comes out until window_length samples have been collected, then every
// sample yields one result with both averages, the calibrated Q16.16 values and
// their Q32.32 product. One item is processed at a time; a sample that yields a
// result runs the bit-serial divider once for each average and the single
// shared multiplier three times. A finished result waits in the output
// register while the next sample is taken in; a second result stalls the
// input until the first one is transferred. Writing window_length restarts
// filling; the user must see that configuration is written only idle, as the
// block itself does not enforce it.
module iv_moving_average_power (
  input  logic                               clk,
  input  logic                               rst_n,
  // current_sample, volts_plus, volts_minus
  input  logic [ivmap_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // current_average, voltage_average, current_scaled, voltage_scaled,
  // power_value, zero pad
  output logic [ivmap_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ivmap_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [ivmap_pkg::CFG_DW-1:0]       cfg_data
);

  ivmap_pkg::cmd_t cmd;
  ivmap_pkg::sts_t sts;
  logic            cfg_wr;

  assign cfg_ready = rst_n;
  assign cfg_wr    = cfg_valid && rst_n;

  ivmap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ivmap_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_wr),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: design/ivmap_checker.sv
module ivmap_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [ivmap_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  // one item in flight: no back-to-back input transfers
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item still in work");

  // a fresh sample cannot produce a result in the very next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind iv_moving_average_power ivmap_checker u_ivmap_checker (.*);
